/* rtl/tscb_pkg.sv */
package tscb_pkg;

	localparam int CW    = 32;
	localparam int EPS_W = 16;
	localparam int MW    = CW + 1;
	localparam int QW    = CW + 1;
	localparam int NW    = 2 * CW + 2;
	localparam int NLANE = 12;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [MW-1:0] mag_t;
	typedef logic [NW-1:0] num_t;
	typedef logic [QW-1:0] quo_t;

	typedef struct packed {
		coord_t      v0_x;
		coord_t      v0_y;
		coord_t      v0_z;
		coord_t      v1_x;
		coord_t      v1_y;
		coord_t      v1_z;
		coord_t      v2_x;
		coord_t      v2_y;
		coord_t      v2_z;
		coord_t      split_low;
		coord_t      split_high;
		logic [1:0]  axis;
	} req_t;

	typedef struct packed {
		logic   hit;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
	} res_t;

	// what travels beside the divider lanes
	typedef struct packed {
		coord_t [2:0][2:0] vtx;
		coord_t            lo;
		coord_t            hi;
		logic [1:0]        ax;
		logic [2:0]        vin;
		logic              eq;
		logic [5:0]        xv;
		logic [11:0]       neg;
	} side_t;

	// the two components that are not the slab axis
	function automatic logic [1:0] other_axis(input logic [1:0] ax, input logic m);
		logic [1:0] r;
		case (ax)
			AX_X: r = m ? AX_Z : AX_Y;
			AX_Y: r = m ? AX_Z : AX_X;
			default: r = m ? AX_Y : AX_X;
		endcase
		return r;
	endfunction

	function automatic mag_t mag(input logic signed [MW-1:0] x);
		mag_t r;
		r = x[MW-1] ? mag_t'(-x) : mag_t'(x);
		return r;
	endfunction

endpackage

/* rtl/tscb_front.sv */
module tscb_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  tscb_pkg::req_t           req,
	input  logic [tscb_pkg::EPS_W-1:0] eps,
	output logic                     out_vld,
	output tscb_pkg::num_t [tscb_pkg::NLANE-1:0] num,
	output tscb_pkg::mag_t [tscb_pkg::NLANE-1:0] den,
	output tscb_pkg::side_t          side
);

	localparam int CW = tscb_pkg::CW;
	localparam int MW = tscb_pkg::MW;
	localparam int NW = tscb_pkg::NW;
	localparam int NL = tscb_pkg::NLANE;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	tscb_pkg::req_t       req_s1;
	logic [tscb_pkg::EPS_W-1:0] eps_s1;
	tscb_pkg::side_t      side_c, side_s2, side_s3, side_s4;
	tscb_pkg::mag_t [2:0] mea_c, mea_s2;
	tscb_pkg::mag_t [5:0] md_c, md_s2, mec_c, mec_s2;
	tscb_pkg::num_t [NL-1:0] prod_s3, num_s4;
	tscb_pkg::mag_t [NL-1:0] den_s3, den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
		eps_s1 <= eps;
	end

	// stage 2: inside tests, edge extents, plane offsets
	always_comb begin
		logic signed [CW+1:0] lo_w, hi_w, a_w;
		logic signed [MW-1:0] a [3];
		logic signed [MW-1:0] ea, d, ec;
		logic [1:0]           oc;
		logic                 inr;
		side_c.vtx[0] = {req_s1.v0_z, req_s1.v0_y, req_s1.v0_x};
		side_c.vtx[1] = {req_s1.v1_z, req_s1.v1_y, req_s1.v1_x};
		side_c.vtx[2] = {req_s1.v2_z, req_s1.v2_y, req_s1.v2_x};
		side_c.lo  = req_s1.split_low;
		side_c.hi  = req_s1.split_high;
		side_c.ax  = (req_s1.axis > tscb_pkg::AX_Z) ? tscb_pkg::AX_Z : req_s1.axis;
		side_c.eq  = (req_s1.split_low == req_s1.split_high);
		side_c.xv  = '0;
		side_c.neg = '0;
		mea_c = '0;
		md_c  = '0;
		mec_c = '0;
		lo_w = (CW+2)'(req_s1.split_low) - $signed({2'b0, CW'(eps_s1)});
		hi_w = (CW+2)'(req_s1.split_high) + $signed({2'b0, CW'(eps_s1)});
		for (int i = 0; i < 3; i++) begin
			a[i] = MW'(side_c.vtx[i][side_c.ax]);
			a_w  = (CW+2)'(side_c.vtx[i][side_c.ax]);
			side_c.vin[i] = (lo_w <= a_w) && (a_w <= hi_w);
		end
		for (int i = 0; i < 3; i++) begin
			ea = a[(i+1)%3] - a[i];
			mea_c[i] = tscb_pkg::mag(ea);
			for (int k = 0; k < 2; k++) begin
				d = (k == 0 ? MW'(req_s1.split_low) : MW'(req_s1.split_high)) - a[i];
				md_c[i*2+k] = tscb_pkg::mag(d);
				inr = ea[MW-1] ? (d <= 0 && d >= ea) : (d >= 0 && d <= ea);
				side_c.xv[i*2+k] = inr && (ea != 0) && !side_c.eq;
			end
			for (int m = 0; m < 2; m++) begin
				oc = tscb_pkg::other_axis(side_c.ax, m[0]);
				ec = MW'(side_c.vtx[(i+1)%3][oc]) - MW'(side_c.vtx[i][oc]);
				mec_c[i*2+m] = tscb_pkg::mag(ec);
				side_c.neg[i*4+m]   = ec[MW-1];
				side_c.neg[i*4+2+m] = ec[MW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_c;
		mea_s2  <= mea_c;
		md_s2   <= md_c;
		mec_s2  <= mec_c;
	end

	// stage 3: one product per lane; lane = edge*4 + plane*2 + component
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 2; k++) begin
				for (int m = 0; m < 2; m++) begin
					prod_s3[i*4+k*2+m] <= NW'(mec_s2[i*2+m] * md_s2[i*2+k]);
					den_s3[i*4+k*2+m]  <= mea_s2[i];
				end
			end
		end
		side_s3 <= side_s2;
	end

	// stage 4: half-denominator bias for round to nearest
	always_ff @(posedge clk) begin
		for (int l = 0; l < NL; l++) begin
			num_s4[l] <= prod_s3[l] + NW'(den_s3[l] >> 1);
		end
		den_s4  <= den_s3;
		side_s4 <= side_s3;
	end

	assign out_vld = vld_s4;
	assign num     = num_s4;
	assign den     = den_s4;
	assign side    = side_s4;

endmodule

/* rtl/tscb_div.sv */
module tscb_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  tscb_pkg::num_t [tscb_pkg::NLANE-1:0] num,
	input  tscb_pkg::mag_t [tscb_pkg::NLANE-1:0] den,
	input  tscb_pkg::side_t                      side_in,
	output logic                                 out_vld,
	output tscb_pkg::quo_t [tscb_pkg::NLANE-1:0] quo,
	output tscb_pkg::side_t                      side_out
);

	localparam int MW = tscb_pkg::MW;
	localparam int QW = tscb_pkg::QW;
	localparam int NL = tscb_pkg::NLANE;

	// one quotient bit per stage, all lanes side by side
	logic                   vld_s  [1:QW];
	tscb_pkg::mag_t [NL-1:0] rem_s [1:QW];
	tscb_pkg::quo_t [NL-1:0] low_s [1:QW];
	tscb_pkg::quo_t [NL-1:0] quo_s [1:QW];
	tscb_pkg::mag_t [NL-1:0] den_s [1:QW];
	tscb_pkg::side_t        side_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                    cur_vld;
		tscb_pkg::mag_t [NL-1:0] cur_rem, cur_den;
		tscb_pkg::quo_t [NL-1:0] cur_low, cur_quo;
		tscb_pkg::side_t         cur_side;

		if (k == 0) begin : g_first
			always_comb begin
				cur_vld  = in_vld;
				cur_den  = den;
				cur_side = side_in;
				cur_quo  = '0;
				for (int l = 0; l < NL; l++) begin
					cur_rem[l] = num[l][tscb_pkg::NW-1:QW];
					cur_low[l] = num[l][QW-1:0];
				end
			end
		end else begin : g_next
			always_comb begin
				cur_vld  = vld_s[k];
				cur_rem  = rem_s[k];
				cur_low  = low_s[k];
				cur_quo  = quo_s[k];
				cur_den  = den_s[k];
				cur_side = side_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			logic [MW:0] t, diff;
			logic        ge;
			for (int l = 0; l < NL; l++) begin
				t    = {cur_rem[l], cur_low[l][QW-1]};
				diff = t - {1'b0, cur_den[l]};
				ge   = (t >= {1'b0, cur_den[l]});
				rem_s[k+1][l] <= ge ? diff[MW-1:0] : t[MW-1:0];
				low_s[k+1][l] <= {cur_low[l][QW-2:0], 1'b0};
				quo_s[k+1][l] <= {cur_quo[l][QW-2:0], ge};
			end
			den_s[k+1]  <= cur_den;
			side_s[k+1] <= cur_side;
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

/* rtl/tscb_merge.sv */
module tscb_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  tscb_pkg::quo_t [tscb_pkg::NLANE-1:0] quo,
	input  tscb_pkg::side_t                      side,
	output logic                                 out_vld,
	output tscb_pkg::res_t                       res
);

	localparam int CW = tscb_pkg::CW;

	typedef struct packed {
		logic                       v;
		tscb_pkg::coord_t [2:0]     mn;
		tscb_pkg::coord_t [2:0]     mx;
	} bx_t;

	function automatic bx_t join_box(input bx_t a, input bx_t b);
		bx_t r;
		if (!a.v) begin
			r = b;
		end else if (!b.v) begin
			r = a;
		end else begin
			r.v = 1'b1;
			for (int c = 0; c < 3; c++) begin
				r.mn[c] = ($signed(b.mn[c]) < $signed(a.mn[c])) ? b.mn[c] : a.mn[c];
				r.mx[c] = ($signed(b.mx[c]) > $signed(a.mx[c])) ? b.mx[c] : a.mx[c];
			end
		end
		return r;
	endfunction

	function automatic bx_t pt_box(input logic v, input tscb_pkg::coord_t [2:0] p);
		bx_t r;
		r.v  = v;
		r.mn = p;
		r.mx = p;
		return r;
	endfunction

	logic                          vld_s1, vld_s2, vld_s3;
	tscb_pkg::coord_t [5:0][2:0]   pt_c, pt_s1;
	tscb_pkg::side_t               side_s1;
	bx_t [2:0]                     grp_s2;
	logic                          eq_s2;
	logic [2:0]                    vin_s2;
	tscb_pkg::res_t                res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// crossing points: axis component is the plane, the others start at the edge origin
	always_comb begin
		logic [1:0]           oc;
		logic signed [CW+1:0] base, q, v;
		pt_c = '0;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 2; k++) begin
				pt_c[i*2+k][side.ax] = (k == 0) ? side.lo : side.hi;
				for (int m = 0; m < 2; m++) begin
					oc   = tscb_pkg::other_axis(side.ax, m[0]);
					base = (CW+2)'(side.vtx[i][oc]);
					q    = $signed({1'b0, quo[i*4+k*2+m]});
					v    = side.neg[i*4+k*2+m] ? base - q : base + q;
					pt_c[i*2+k][oc] = v[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pt_s1   <= pt_c;
		side_s1 <= side;
	end

	always_ff @(posedge clk) begin
		grp_s2[0] <= join_box(join_box(pt_box(side_s1.vin[0], side_s1.vtx[0]),
			pt_box(side_s1.vin[1], side_s1.vtx[1])), pt_box(side_s1.vin[2], side_s1.vtx[2]));
		grp_s2[1] <= join_box(join_box(pt_box(side_s1.xv[0], pt_s1[0]),
			pt_box(side_s1.xv[1], pt_s1[1])), pt_box(side_s1.xv[2], pt_s1[2]));
		grp_s2[2] <= join_box(join_box(pt_box(side_s1.xv[3], pt_s1[3]),
			pt_box(side_s1.xv[4], pt_s1[4])), pt_box(side_s1.xv[5], pt_s1[5]));
		eq_s2  <= side_s1.eq;
		vin_s2 <= side_s1.vin;
	end

	always_ff @(posedge clk) begin
		bx_t all;
		logic two_in;
		all    = join_box(join_box(grp_s2[0], grp_s2[1]), grp_s2[2]);
		two_in = (vin_s2[0] & vin_s2[1]) | (vin_s2[1] & vin_s2[2]) | (vin_s2[0] & vin_s2[2]);
		res_s3.hit       <= eq_s2 ? two_in : all.v;
		res_s3.box_min_x <= all.v ? all.mn[0] : '0;
		res_s3.box_min_y <= all.v ? all.mn[1] : '0;
		res_s3.box_min_z <= all.v ? all.mn[2] : '0;
		res_s3.box_max_x <= all.v ? all.mx[0] : '0;
		res_s3.box_max_y <= all.v ? all.mx[1] : '0;
		res_s3.box_max_z <= all.v ? all.mx[2] : '0;
	end

	assign out_vld = vld_s3;
	assign res     = res_s3;

endmodule

/* rtl/triangle_slab_clip_bbox.sv */
// channel   signals                  handshake
// request   start, busy, req         taken when start is high and busy is low
// result    done, result             one cycle per result, strobed by done, no back pressure
// config    cfg_we, cfg_data         epsilon written when cfg_we is high
//
// one request per cycle; pipeline of 4 front stages, 33 divider stages
// (one quotient bit per stage, the depth of the rounding divider), 3 merge stages.
// busy never rises: the pipeline always moves.
// reset clears the valid bits and sets epsilon to 1.
module triangle_slab_clip_bbox (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tscb_pkg::req_t              req,
	output logic                        done,
	output tscb_pkg::res_t              result,
	input  logic                        cfg_we,
	input  logic [tscb_pkg::EPS_W-1:0]  cfg_data
);

	logic [tscb_pkg::EPS_W-1:0] eps_q;
	logic                       f_vld, d_vld;
	tscb_pkg::num_t [tscb_pkg::NLANE-1:0] f_num;
	tscb_pkg::mag_t [tscb_pkg::NLANE-1:0] f_den;
	tscb_pkg::quo_t [tscb_pkg::NLANE-1:0] d_quo;
	tscb_pkg::side_t            f_side, d_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= tscb_pkg::EPS_W'(1);
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	tscb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start & ~busy),
		.req     (req),
		.eps     (eps_q),
		.out_vld (f_vld),
		.num     (f_num),
		.den     (f_den),
		.side    (f_side)
	);

	tscb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (f_vld),
		.num      (f_num),
		.den      (f_den),
		.side_in  (f_side),
		.out_vld  (d_vld),
		.quo      (d_quo),
		.side_out (d_side)
	);

	tscb_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (d_vld),
		.quo     (d_quo),
		.side    (d_side),
		.out_vld (done),
		.res     (result)
	);

endmodule
